@@ src/fed_pkg.sv @@
// ----------------------------------------------------------------------------
// fed_pkg: shared types and constants of the feedback echo delay
// Register codes, field widths, reset values and the gain rounding constants.
// ----------------------------------------------------------------------------
package fed_pkg;

	localparam int LEN_W     = 17;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W    = 16;

	typedef logic [CFG_W-1:0]     cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [GAIN_W-1:0]    gain_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH  = 2'd0,
		REG_FEEDBACK_GAIN = 2'd1,
		REG_MIX_LEVEL     = 2'd2
	} reg_index_t;

	localparam len_t  DELAY_RESET     = 17'd24000;
	localparam gain_t GAIN_RESET      = 16'd0;
	localparam gain_t MIX_RESET       = 16'd32768;
	// zero gain stands for roughly 0.1 in Q0.16
	localparam gain_t GAIN_ZERO_SUBST = 16'd6554;
	localparam int    ROUND_HALF      = 32768;

endpackage

@@ src/fed_in_if.sv @@
// ----------------------------------------------------------------------------
// fed_in_if: input sample channel
// Valid/ready channel carrying one dry sample word.
// ----------------------------------------------------------------------------
interface fed_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

@@ src/fed_out_if.sv @@
// ----------------------------------------------------------------------------
// fed_out_if: output sample channel
// Valid/ready channel carrying one echoed sample word.
// ----------------------------------------------------------------------------
interface fed_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

@@ src/fed_ram.sv @@
// ----------------------------------------------------------------------------
// fed_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fed_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 131072
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ src/fed_mul.sv @@
// ----------------------------------------------------------------------------
// fed_mul: shared Q0.16 scaling unit
// Signed word times unsigned Q0.16 gain, round half up, registered result.
// ----------------------------------------------------------------------------
module fed_mul #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] a,
	input  fed_pkg::gain_t                b,
	output logic signed [SAMPLE_BITS-1:0] result_q
);
	import fed_pkg::*;

	localparam int PW = SAMPLE_BITS + GAIN_W + 1;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rounded;

	always_comb begin
		prod    = PW'(a) * PW'($signed({1'b0, b}));
		rounded = prod + PW'(ROUND_HALF);
	end

	// arithmetic drop of the fraction is a floor; magnitude never grows
	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= rounded[FRAC_W +: SAMPLE_BITS];
		end
	end
endmodule

@@ src/feedback_echo_delay.sv @@
// ----------------------------------------------------------------------------
// feedback_echo_delay: feedback comb echo on one sample stream
// Sequencer around one shared scaling multiplier and a circular echo store.
// ----------------------------------------------------------------------------
// The accept cycle reads the echo store, ST_MUL_FB and ST_MUL_MIX run the
// shared multiplier (first by the feedback gain, then by the mix level), and
// ST_DONE saturates the sum, writes it back into the store and loads the
// output register. The input is not ready from an accept until the sequence
// is back in ST_IDLE; the last step also waits while an earlier result still
// sits unread in the output register. There is no clearing pass after reset:
// the store is filled in write order, so a slot not yet written since reset
// is recognised from the write pointer and reads as zero.
// delay_length is reduced modulo STORE_DEPTH when written; zero delay reads
// the slot about to be overwritten. Interleaved stereo passes as one stream.
// ----------------------------------------------------------------------------
module feedback_echo_delay #(
	parameter int STORE_DEPTH = 131072,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  fed_pkg::cfg_index_t    cfg_index,
	input  fed_pkg::cfg_data_t     cfg_data,
	fed_in_if.sink                 dry,
	fed_out_if.source              wet
);
	import fed_pkg::*;

	localparam int AW        = $clog2(STORE_DEPTH);
	localparam int LOG_FLOOR = $clog2(STORE_DEPTH + 1) - 1;
	// number of compare-subtract steps to bring a 17-bit length below depth
	localparam int MOD_STEPS = (LEN_W > LOG_FLOOR) ? (LEN_W - LOG_FLOOR) : 0;
	localparam len_t DEPTH_L = LEN_W'(STORE_DEPTH);

	typedef logic [AW-1:0] addr_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL_FB,
		ST_MUL_MIX,
		ST_DONE
	} state_t;

	function automatic addr_t reduce_len(input len_t v);
		len_t r;
		r = v;
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (r >= (DEPTH_L << k)) begin
				r = r - (DEPTH_L << k);
			end
		end
		return AW'(r);
	endfunction

	// configuration
	addr_t len_q;
	gain_t gain_q;
	gain_t mix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= reduce_len(DELAY_RESET);
			gain_q <= GAIN_RESET;
			mix_q  <= MIX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY_LENGTH:  len_q  <= reduce_len(cfg_data[LEN_W-1:0]);
				REG_FEEDBACK_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				REG_MIX_LEVEL:     mix_q  <= cfg_data[GAIN_W-1:0];
				default:           ;
			endcase
		end
	end

	// sequencer state
	state_t  state_q;
	addr_t   wp_q;
	logic    wrapped_q;
	logic    rd_valid_q;
	sample_t x_q;
	logic    out_valid_q;
	sample_t out_sample_q;

	logic    in_fire;
	logic    out_free;
	logic    done_fire;
	logic [AW:0] rd_diff;
	addr_t   rd_addr;
	logic    rd_valid;
	sample_t store_rdata;
	sample_t mul_a;
	gain_t   mul_b;
	logic    mul_en;
	sample_t mul_q;
	logic signed [SAMPLE_BITS:0] sum;
	sample_t sum_sat;

	assign dry.ready  = (state_q == ST_IDLE);
	assign in_fire    = dry.valid && dry.ready;
	assign out_free   = !out_valid_q || wet.ready;
	assign done_fire  = (state_q == ST_DONE) && out_free;
	assign wet.valid  = out_valid_q;
	assign wet.sample_out = out_sample_q;

	// read slot lies delay_length words behind the write pointer
	always_comb begin
		rd_diff = {1'b0, wp_q} - {1'b0, len_q};
		if (rd_diff[AW]) begin
			rd_diff = rd_diff + (AW + 1)'(STORE_DEPTH);
		end
		rd_addr  = rd_diff[AW-1:0];
		// slots above the write pointer are unwritten until the first wrap
		rd_valid = wrapped_q || (rd_addr < wp_q);
	end

	fed_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (done_fire),
		.waddr(wp_q),
		.wdata(sum_sat),
		.re   (in_fire),
		.raddr(rd_addr),
		.rdata(store_rdata)
	);

	// feed the shared multiplier: delayed word by gain, then that by mix
	always_comb begin
		mul_en = (state_q == ST_MUL_FB) || (state_q == ST_MUL_MIX);
		if (state_q == ST_MUL_FB) begin
			mul_a = rd_valid_q ? store_rdata : '0;
			mul_b = (gain_q == '0) ? GAIN_ZERO_SUBST : gain_q;
		end else begin
			mul_a = mul_q;
			mul_b = mix_q;
		end
	end

	fed_mul #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mul (
		.clk     (clk),
		.en      (mul_en),
		.a       (mul_a),
		.b       (mul_b),
		.result_q(mul_q)
	);

	// saturating add of dry word and scaled echo
	always_comb begin
		sum = {x_q[SAMPLE_BITS-1], x_q} + {mul_q[SAMPLE_BITS-1], mul_q};
		if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1]) begin
			sum_sat = sum[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else begin
			sum_sat = sum[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the taken word unless a new one replaces it
			if (wet.ready && !done_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						x_q        <= dry.sample_in;
						rd_valid_q <= rd_valid;
						state_q    <= ST_MUL_FB;
					end
				end
				ST_MUL_FB: begin
					state_q <= ST_MUL_MIX;
				end
				ST_MUL_MIX: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold while the previous word is still unread
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= sum_sat;
						if (wp_q == AW'(STORE_DEPTH - 1)) begin
							wp_q      <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wp_q <= wp_q + addr_t'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

@@ src/fed_checker.sv @@
// ----------------------------------------------------------------------------
// fed_checker: port-level checks of the feedback echo delay
// Busy window after accept, result only after an accept, and stalled output hold.
// ----------------------------------------------------------------------------
module fed_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_sample
);
	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// busy while the sequence runs through MUL_FB, MUL_MIX and DONE
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input ready during word sequence");

	// a rising output valid traces back to an accept, through MUL_FB, MUL_MIX and DONE
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc, 4))
		else $error("result without matching accept");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("stalled result changed");
endmodule

bind feedback_echo_delay fed_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_fed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (dry.valid),
	.in_ready  (dry.ready),
	.out_valid (wet.valid),
	.out_ready (wet.ready),
	.out_sample(wet.sample_out)
);
